/* rtl/lcs_pkg.sv */
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants for the LCS length engine
// Request payloads, opcode and default capacity of the string A store.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int MAX_A_DEF = 256;
  localparam int CH_W      = 8;
  localparam int LCS_W     = 9;

  typedef enum logic {
    OP_A = 1'b0,
    OP_B = 1'b1
  } op_t;

  typedef struct packed {
    op_t             operation;
    logic [CH_W-1:0] ch;
    logic            no_char;
    logic            last;
  } in_t;

  typedef struct packed {
    logic [LCS_W-1:0] lcs_length;
    logic             overflow;
  } out_t;

  // B character travelling along the cell chain
  typedef struct packed {
    logic            valid;
    logic            has_char;
    logic            last;
    logic [CH_W-1:0] ch;
  } tok_t;

  // per-cell control, broadcast from the top level
  typedef struct packed {
    logic adv;    // chain advances this cycle
    logic flush;  // start of a new case: drop row, tokens and stored char
    logic wr;     // load the A character into this cell
  } cell_ctrl_t;

endpackage

/* rtl/lcs_cell.sv */
// ----------------------------------------------------------------------------
// lcs_cell: one position of string A in the systolic DP row
// Holds one A character and its match length; updates it as a B character
// passes and hands diag/left values to the next cell.
// ----------------------------------------------------------------------------
module lcs_cell #(
  parameter int LW = lcs_pkg::LCS_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lcs_pkg::cell_ctrl_t     ctrl,
  input  logic [lcs_pkg::CH_W-1:0] wr_ch,
  input  lcs_pkg::tok_t           tok_i,
  input  logic [LW-1:0]           diag_i,
  input  logic [LW-1:0]           left_i,
  output lcs_pkg::tok_t           tok_o,
  output logic [LW-1:0]           diag_o,
  output logic [LW-1:0]           left_o
);

  logic [lcs_pkg::CH_W-1:0] ch_r;
  logic                     vld_r;
  logic [LW-1:0]            row_r;
  lcs_pkg::tok_t            tok_r;
  logic [LW-1:0]            diag_r;
  logic [LW-1:0]            left_r;
  logic                     hit;
  logic [LW-1:0]            val_nxt;

  assign hit = tok_i.valid && tok_i.has_char && vld_r;

  always_comb begin
    if (ch_r == tok_i.ch) begin
      val_nxt = diag_i + LW'(1);
    end else begin
      val_nxt = (left_i > row_r) ? left_i : row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      row_r <= '0;
      tok_r <= '0;
    end else begin
      if (ctrl.flush) begin
        vld_r <= 1'b0;
        row_r <= '0;
        tok_r <= '0;
      end else if (ctrl.adv) begin
        tok_r <= tok_i;
        if (hit) begin
          row_r <= val_nxt;
        end
      end
      if (ctrl.wr) begin
        vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      ch_r <= wr_ch;
    end
    if (ctrl.adv) begin
      // unused positions pass the diag and left values on unchanged
      diag_r <= vld_r ? row_r : diag_i;
      left_r <= vld_r ? (hit ? val_nxt : row_r) : left_i;
    end
  end

  assign tok_o  = tok_r;
  assign diag_o = diag_r;
  assign left_o = left_r;

endmodule

/* rtl/lcs_length.sv */
// ----------------------------------------------------------------------------
// lcs_length: longest common subsequence length of two byte strings
// String A is loaded into a row of cells; each B character then sweeps the
// row as a wavefront, one cell per cycle while the chain is not held, and the last B yields the length.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_ready   | lcs_pkg::in_t  (operation, ch, no_char, last)
// out_    | output    | out_valid/out_ready | lcs_pkg::out_t (lcs_length, overflow)
//
// A and B requests are taken one per cycle while in_ready is high.
// After the last B request the result reaches the output register once the
// wavefront has crossed every cell: it moves one cell per cycle unless the chain is held.
// in_ready stays low from the last B request until its result is registered.
// A stalled result holds the cell chain when the next result reaches the tail; reset is synchronous.
// ----------------------------------------------------------------------------
module lcs_length #(
  parameter int MAX_A = lcs_pkg::MAX_A_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lcs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lcs_pkg::out_t out_data
);

  localparam int LW  = $clog2(MAX_A + 1);
  localparam int ALW = $clog2(MAX_A + 1);
  localparam int AW  = (MAX_A > 1) ? $clog2(MAX_A) : 1;

  logic            a_acc;
  logic            is_b;
  logic            abandon;
  logic            tail_last;
  logic            adv;
  logic            done;
  logic            flush;
  logic            wr_en;
  logic [AW-1:0]   wr_idx;
  logic [ALW-1:0]  len_base;
  logic            ovf_base;

  logic [ALW-1:0]  a_len_r, a_len_nxt;
  logic            ovf_r, ovf_nxt;
  logic            loading_r, loading_nxt;
  logic            wait_r, wait_nxt;
  logic            out_valid_r;
  lcs_pkg::out_t   out_data_r;

  lcs_pkg::tok_t   tok_in;
  lcs_pkg::tok_t   tok_w  [MAX_A];
  logic [LW-1:0]   diag_w [MAX_A];
  logic [LW-1:0]   left_w [MAX_A];
  lcs_pkg::cell_ctrl_t ctrl_w [MAX_A];
  logic [lcs_pkg::LCS_W-1:0] sat_len;

  assign in_ready  = !wait_r;
  assign a_acc     = in_valid && in_ready;
  assign is_b      = (in_data.operation == lcs_pkg::OP_B);
  assign abandon   = a_acc && !is_b && !loading_r;
  assign tail_last = tok_w[MAX_A-1].valid && tok_w[MAX_A-1].last;
  assign adv       = !(tail_last && out_valid_r && !out_ready);
  assign done      = tail_last && adv;
  assign flush     = abandon || done;

  assign len_base = abandon ? '0 : a_len_r;
  assign ovf_base = abandon ? 1'b0 : ovf_r;
  assign wr_en    = a_acc && !is_b && !in_data.no_char && (len_base < ALW'(MAX_A));
  assign wr_idx   = len_base[AW-1:0];

  always_comb begin
    tok_in.valid    = a_acc && is_b;
    tok_in.has_char = !in_data.no_char;
    tok_in.last     = in_data.last;
    tok_in.ch       = in_data.ch;
  end

  always_comb begin
    a_len_nxt   = a_len_r;
    ovf_nxt     = ovf_r;
    loading_nxt = loading_r;
    wait_nxt    = wait_r;
    if (done) begin
      a_len_nxt   = '0;
      ovf_nxt     = 1'b0;
      loading_nxt = 1'b1;
      wait_nxt    = 1'b0;
    end else if (a_acc) begin
      if (is_b) begin
        loading_nxt = 1'b0;
        wait_nxt    = in_data.last;
      end else begin
        a_len_nxt   = len_base;
        ovf_nxt     = ovf_base;
        loading_nxt = !in_data.last;
        if (!in_data.no_char) begin
          if (len_base < ALW'(MAX_A)) begin
            a_len_nxt = len_base + ALW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
    end
  end

  generate
    if (LW > lcs_pkg::LCS_W) begin : g_sat
      assign sat_len = (|left_w[MAX_A-1][LW-1:lcs_pkg::LCS_W]) ? '1 :
                       left_w[MAX_A-1][lcs_pkg::LCS_W-1:0];
    end else begin : g_nosat
      assign sat_len = lcs_pkg::LCS_W'(left_w[MAX_A-1]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_len_r     <= '0;
      ovf_r       <= 1'b0;
      loading_r   <= 1'b1;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_len_r   <= a_len_nxt;
      ovf_r     <= ovf_nxt;
      loading_r <= loading_nxt;
      wait_r    <= wait_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r.lcs_length <= sat_len;
      out_data_r.overflow   <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  genvar k;
  generate
    for (k = 0; k < MAX_A; k++) begin : g_cell
      assign ctrl_w[k].adv   = adv;
      assign ctrl_w[k].flush = flush;
      assign ctrl_w[k].wr    = wr_en && (wr_idx == AW'(k));

      if (k == 0) begin : g_head
        lcs_cell #(.LW(LW)) u_cell (
          .clk    (clk),
          .rst_n  (rst_n),
          .ctrl   (ctrl_w[k]),
          .wr_ch  (in_data.ch),
          .tok_i  (tok_in),
          .diag_i ('0),
          .left_i ('0),
          .tok_o  (tok_w[k]),
          .diag_o (diag_w[k]),
          .left_o (left_w[k])
        );
      end else begin : g_body
        lcs_cell #(.LW(LW)) u_cell (
          .clk    (clk),
          .rst_n  (rst_n),
          .ctrl   (ctrl_w[k]),
          .wr_ch  (in_data.ch),
          .tok_i  (tok_w[k-1]),
          .diag_i (diag_w[k-1]),
          .left_i (left_w[k-1]),
          .tok_o  (tok_w[k]),
          .diag_o (diag_w[k]),
          .left_o (left_w[k])
        );
      end
    end
  endgenerate

  // a result only shows up while a last B request is outstanding
  a_out_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(wait_r))
    else $error("result without pending last B request");

  // closing B request blocks input and ends A loading
  a_last_b_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (a_acc && is_b && in_data.last) |=> (wait_r && !loading_r && !in_ready))
    else $error("last B request did not block input");

  // stored A length never exceeds the cell count
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    a_len_r <= ALW'(MAX_A))
    else $error("A length beyond capacity");

endmodule
